### hw/rtl/tvca_pkg.sv
// Shared types, constants and helpers for the timed voice channel allocator.
`timescale 1ns / 1ps

package tvca_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    typedef enum logic [1:0] {
        FUNC_ADD     = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_TICK    = 2'd2,
        FUNC_PANIC   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CMD_SILENCE = 2'd0,
        CMD_START   = 2'd1,
        CMD_STATUS  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_STATUS
    } state_t;

    typedef struct packed {
        func_t       func;
        logic [31:0] now;
        logic [31:0] stop;
        logic [7:0]  lch;
        logic [19:0] freq;
        logic [15:0] width;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic        placed;
        logic        freed;
        logic        nv;
        logic [31:0] nt;
    } carry_t;

    typedef struct packed {
        logic silence;
        logic take;
    } evt_t;

    function automatic logic [2:0] chan_code(input logic [IDX_W-1:0] idx);
        logic [IDX_W+2:0] wide;
        wide = {3'b000, idx};
        return wide[2:0];
    endfunction

endpackage

### hw/rtl/timed_voice_channel_allocator_core.sv
// Top level of the timed voice channel allocator: sequencer and chain of channel cells.
`timescale 1ns / 1ps
// Usage: a request is taken at a rising edge where start is high and busy is low.
// func selects add note, release logical channel, time tick or panic; the other
// input ports carry the request fields and are sampled at that edge only.
// A token runs down a row of NUM_CHANNELS cells, one cell per cycle; each cell
// holds one physical channel and decides locally whether it is freed or takes
// the note, and folds its stop time into the running earliest-stop search.
// Results leave on the result ports, one per cycle, marked by result_valid:
// silence commands in channel order during the scan, then a start command if
// a note was placed, then the status transaction with last set.
// The status transaction follows the token walk through the cell row and,
// when a note is placed, the start command. busy drops in the cycle the
// status is shown, so a new request may be taken at the edge that ends it.
// The receiver cannot stall; every result is valid for exactly one cycle.
// Reset clears all channels to idle with zero stop time, owner, frequency and width.
module timed_voice_channel_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [31:0] now_time,
    input  logic [31:0] start_time,
    input  logic [31:0] note_length,
    input  logic [7:0]  logical_channel,
    input  logic [19:0] tone_freq,
    input  logic [15:0] duty_width,
    output logic        result_valid,
    output logic [1:0]  cmd_kind,
    output logic [2:0]  channel_index,
    output logic [19:0] out_freq,
    output logic [15:0] out_width,
    output logic        success,
    output logic        next_valid,
    output logic [31:0] next_event_time,
    output logic        last
);

    localparam int N = tvca_pkg::NUM_CHANNELS;
    localparam logic [tvca_pkg::IDX_W-1:0] IDX_LAST = tvca_pkg::IDX_W'(N - 1);

    tvca_pkg::state_t state_reg, state_next;
    tvca_pkg::item_t  item_reg, item_next;
    logic [tvca_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [tvca_pkg::IDX_W-1:0] place_reg, place_next;
    logic             launch_reg, launch_next;
    logic             ok_reg, ok_next;
    logic             nv_reg, nv_next;
    logic [31:0]      nt_reg, nt_next;

    logic             rv_reg, rv_next;
    tvca_pkg::cmd_t   kind_reg, kind_next;
    logic [2:0]       ch_reg, ch_next;
    logic [19:0]      rfreq_reg, rfreq_next;
    logic [15:0]      rwidth_reg, rwidth_next;
    logic             rok_reg, rok_next;
    logic             rnv_reg, rnv_next;
    logic [31:0]      rnt_reg, rnt_next;
    logic             rlast_reg, rlast_next;

    tvca_pkg::carry_t chain [N+1];
    tvca_pkg::evt_t   evts [N];
    tvca_pkg::evt_t   evt_any;
    logic [32:0]      stop_sum;
    logic             final_ok;

    assign chain[0] = '{valid: launch_reg, placed: 1'b0, freed: 1'b0, nv: 1'b0, nt: 32'd0};

    for (genvar g = 0; g < N; g++)
    begin : g_chan
        tvca_cell u_chan (
            .clk   (clk),
            .rst_n (rst_n),
            .item  (item_reg),
            .cin   (chain[g]),
            .cout  (chain[g+1]),
            .evt   (evts[g])
        );
    end

    always_comb
    begin
        evt_any = '0;
        for (int k = 0; k < N; k++)
        begin
            evt_any = evt_any | evts[k];
        end
    end

    assign stop_sum = {1'b0, start_time} + {1'b0, note_length};

    always_comb
    begin
        case (item_reg.func)
            tvca_pkg::FUNC_ADD:     final_ok = chain[N].placed;
            tvca_pkg::FUNC_RELEASE: final_ok = chain[N].freed;
            default:                final_ok = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        idx_next    = idx_reg;
        place_next  = place_reg;
        launch_next = 1'b0;
        ok_next     = ok_reg;
        nv_next     = nv_reg;
        nt_next     = nt_reg;
        rv_next     = 1'b0;
        kind_next   = tvca_pkg::CMD_SILENCE;
        ch_next     = 3'd0;
        rfreq_next  = 20'd0;
        rwidth_next = 16'd0;
        rok_next    = 1'b0;
        rnv_next    = 1'b0;
        rnt_next    = 32'd0;
        rlast_next  = 1'b0;
        case (state_reg)
            tvca_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    item_next.func  = tvca_pkg::func_t'(func);
                    item_next.now   = now_time;
                    item_next.stop  = stop_sum[32] ? 32'hFFFF_FFFF : stop_sum[31:0];
                    item_next.lch   = logical_channel;
                    item_next.freq  = tone_freq;
                    item_next.width = duty_width;
                    launch_next     = 1'b1;
                    idx_next        = '0;
                    state_next      = tvca_pkg::ST_SCAN;
                end
            end
            tvca_pkg::ST_SCAN:
            begin
                if (evt_any.silence)
                begin
                    rv_next   = 1'b1;
                    kind_next = tvca_pkg::CMD_SILENCE;
                    ch_next   = tvca_pkg::chan_code(idx_reg);
                end
                if (evt_any.take)
                begin
                    place_next = idx_reg;
                end
                if (idx_reg == IDX_LAST)
                begin
                    state_next = tvca_pkg::ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            tvca_pkg::ST_FINISH:
            begin
                ok_next = final_ok;
                nv_next = chain[N].nv;
                nt_next = chain[N].nt;
                rv_next = 1'b1;
                if (chain[N].placed)
                begin
                    kind_next   = tvca_pkg::CMD_START;
                    ch_next     = tvca_pkg::chan_code(place_reg);
                    rfreq_next  = item_reg.freq;
                    rwidth_next = item_reg.width;
                    state_next  = tvca_pkg::ST_STATUS;
                end
                else
                begin
                    kind_next  = tvca_pkg::CMD_STATUS;
                    rok_next   = final_ok;
                    rnv_next   = chain[N].nv;
                    rnt_next   = chain[N].nt;
                    rlast_next = 1'b1;
                    state_next = tvca_pkg::ST_IDLE;
                end
            end
            tvca_pkg::ST_STATUS:
            begin
                rv_next    = 1'b1;
                kind_next  = tvca_pkg::CMD_STATUS;
                rok_next   = ok_reg;
                rnv_next   = nv_reg;
                rnt_next   = nt_reg;
                rlast_next = 1'b1;
                state_next = tvca_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tvca_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tvca_pkg::ST_IDLE;
            launch_reg <= 1'b0;
            rv_reg     <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            rv_reg     <= rv_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        place_reg  <= place_next;
        ok_reg     <= ok_next;
        nv_reg     <= nv_next;
        nt_reg     <= nt_next;
        kind_reg   <= kind_next;
        ch_reg     <= ch_next;
        rfreq_reg  <= rfreq_next;
        rwidth_reg <= rwidth_next;
        rok_reg    <= rok_next;
        rnv_reg    <= rnv_next;
        rnt_reg    <= rnt_next;
        rlast_reg  <= rlast_next;
    end

    assign busy            = (state_reg != tvca_pkg::ST_IDLE);
    assign result_valid    = rv_reg;
    assign cmd_kind        = kind_reg;
    assign channel_index   = ch_reg;
    assign out_freq        = rfreq_reg;
    assign out_width       = rwidth_reg;
    assign success         = rok_reg;
    assign next_valid      = rnv_reg;
    assign next_event_time = rnt_reg;
    assign last            = rlast_reg && rv_reg;

endmodule

### hw/rtl/tvca_cell.sv
// One physical channel cell of the allocator chain.
`timescale 1ns / 1ps

module tvca_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  tvca_pkg::item_t  item,
    input  tvca_pkg::carry_t cin,
    output tvca_pkg::carry_t cout,
    output tvca_pkg::evt_t   evt
);

    logic             busy_reg, busy_next;
    logic [31:0]      stop_reg, stop_next;
    logic [7:0]       owner_reg, owner_next;
    logic [19:0]      freq_reg, freq_next;
    logic [15:0]      width_reg, width_next;
    tvca_pkg::carry_t cout_reg, cout_next;

    logic free_now;
    logic busy_kept;
    logic take_now;

    always_comb
    begin
        busy_next  = busy_reg;
        stop_next  = stop_reg;
        owner_next = owner_reg;
        freq_next  = freq_reg;
        width_next = width_reg;
        cout_next  = '0;
        evt        = '0;
        free_now   = 1'b0;
        busy_kept  = busy_reg;
        take_now   = 1'b0;
        if (cin.valid)
        begin
            case (item.func)
                tvca_pkg::FUNC_ADD,
                tvca_pkg::FUNC_TICK:    free_now = busy_reg && (stop_reg <= item.now);
                tvca_pkg::FUNC_RELEASE: free_now = busy_reg && (owner_reg == item.lch);
                tvca_pkg::FUNC_PANIC:   free_now = 1'b1;
                default:                free_now = 1'b0;
            endcase
            busy_kept = busy_reg && !free_now;
            take_now  = (item.func == tvca_pkg::FUNC_ADD) && !busy_kept && !cin.placed;

            if (free_now)
            begin
                owner_next = 8'd0;
            end
            if (item.func == tvca_pkg::FUNC_PANIC)
            begin
                freq_next  = 20'd0;
                width_next = 16'd0;
            end
            busy_next = busy_kept || take_now;
            if (take_now)
            begin
                stop_next  = item.stop;
                owner_next = item.lch;
                freq_next  = item.freq;
                width_next = item.width;
            end

            evt.silence = free_now;
            evt.take    = take_now;

            cout_next.valid  = 1'b1;
            cout_next.placed = cin.placed || take_now;
            cout_next.freed  = cin.freed || free_now;
            cout_next.nv     = cin.nv;
            cout_next.nt     = cin.nt;
            if (busy_next && (!cin.nv || (stop_next < cin.nt)))
            begin
                cout_next.nv = 1'b1;
                cout_next.nt = stop_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            stop_reg  <= 32'd0;
            owner_reg <= 8'd0;
            freq_reg  <= 20'd0;
            width_reg <= 16'd0;
            cout_reg  <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            stop_reg  <= stop_next;
            owner_reg <= owner_next;
            freq_reg  <= freq_next;
            width_reg <= width_next;
            cout_reg  <= cout_next;
        end
    end

    assign cout = cout_reg;

endmodule

### hw/rtl/tvca_checker.sv
// Port-level checker for the timed voice channel allocator and its bind statement.
`timescale 1ns / 1ps

module tvca_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        result_valid,
    input logic [1:0]  cmd_kind,
    input logic        success,
    input logic        next_valid,
    input logic [31:0] next_event_time,
    input logic        last
);

    // The status transaction always closes a request, and nothing else does.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (cmd_kind == tvca_pkg::CMD_STATUS) |-> last)
        else $error("status transaction without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        last |-> result_valid && (cmd_kind == tvca_pkg::CMD_STATUS))
        else $error("last on a transaction that is not status");

    // A new request is free to enter once its status is on the ports.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy)
        else $error("still busy while status is shown");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("command transaction outside a request");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (cmd_kind != tvca_pkg::CMD_STATUS)
            |-> !success && !next_valid && (next_event_time == 32'd0))
        else $error("status fields set on a channel command");

endmodule

bind timed_voice_channel_allocator_core tvca_checker u_tvca_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .busy            (busy),
    .result_valid    (result_valid),
    .cmd_kind        (cmd_kind),
    .success         (success),
    .next_valid      (next_valid),
    .next_event_time (next_event_time),
    .last            (last)
);
